FILE: hdl/cds_pkg.sv
package cds_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned OP_W    = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
  localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] APRIL    = 4'd4;
  localparam logic [MONTH_W-1:0] JUNE     = 4'd6;
  localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
  localparam logic [MONTH_W-1:0] NOVEMBER = 4'd11;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  localparam logic [DAY_W-1:0] WEEK_DAYS = 5'd7;

  // multiplicative inverse of 25 modulo 2**YEAR_W; y is a multiple of 25
  // exactly when y * inverse (mod 2**YEAR_W) is at most (2**YEAR_W - 1) / 25
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

  typedef enum logic [OP_W-1:0] {
    OP_DAY_BACK   = 3'd0,
    OP_DAY_FWD    = 3'd1,
    OP_WEEK_BACK  = 3'd2,
    OP_WEEK_FWD   = 3'd3,
    OP_MONTH_BACK = 3'd4,
    OP_MONTH_FWD  = 3'd5,
    OP_LOAD       = 3'd6,
    OP_NOP        = 3'd7
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [YEAR_W-1:0]  load_year;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_day;
  } cmd_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t              date;
    logic [DAY_W-1:0]   month_length;
    logic               limit_hit;
  } res_t;

  // full gregorian rule: by 4, and not by 100 unless by 400
  function automatic logic is_leap(logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div4;
    logic                div16;
    logic                div25;
    prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV25};
    div4  = (y[1:0] == 2'd0);
    div16 = (y[3:0] == 4'd0);
    div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
    return div4 && (!div25 || div16);
  endfunction

  // months out of range read as january or december, both 31 days
  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    if (m == FEBRUARY) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == APRIL || m == JUNE || m == SEPTEMBER || m == NOVEMBER) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

FILE: hdl/cds_in_reg.sv
module cds_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  cds_pkg::cmd_t cmd_i,
  output logic          valid_o,
  input  logic          take_i,
  output cds_pkg::cmd_t cmd_o
);

  logic          valid_q, valid_d;
  cds_pkg::cmd_t cmd_q;

  // refill in the same cycle the held command moves on
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cmd_q <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

FILE: hdl/cds_date_next.sv
module cds_date_next (
  input  cds_pkg::date_t cur_i,
  input  cds_pkg::cmd_t  cmd_i,
  output cds_pkg::res_t  res_o
);

  logic                          leap_cur;
  logic                          leap_ld;
  logic [cds_pkg::DAY_W-1:0]     dim;
  logic [cds_pkg::MONTH_W-1:0]   prev_m, next_m;
  logic [cds_pkg::YEAR_W-1:0]    prev_y, next_y;
  logic                          wrap_back, wrap_fwd;
  logic                          under, over;
  logic [cds_pkg::DAY_W-1:0]     len_prev, len_next;
  logic [cds_pkg::DAY_W:0]       day_plus7;
  logic [cds_pkg::DAY_W:0]       week_back_day;
  logic [cds_pkg::MONTH_W-1:0]   ld_m;
  logic [cds_pkg::DAY_W-1:0]     ld_len;
  logic [cds_pkg::DAY_W-1:0]     ld_d;
  logic                          ld_bad;
  cds_pkg::date_t                nxt;
  logic                          refuse;
  logic                          new_leap;

  assign leap_cur = cds_pkg::is_leap(cur_i.year);
  assign leap_ld  = cds_pkg::is_leap(cmd_i.load_year);
  assign dim      = cds_pkg::month_len(cur_i.month, leap_cur);

  // neighbor months; a year change always lands in january or december
  assign wrap_back = (cur_i.month == cds_pkg::JANUARY);
  assign wrap_fwd  = (cur_i.month == cds_pkg::DECEMBER);
  assign prev_m    = wrap_back ? cds_pkg::DECEMBER : cur_i.month - 4'd1;
  assign next_m    = wrap_fwd ? cds_pkg::JANUARY : cur_i.month + 4'd1;
  assign prev_y    = wrap_back ? cur_i.year - 14'd1 : cur_i.year;
  assign next_y    = wrap_fwd ? cur_i.year + 14'd1 : cur_i.year;
  assign under     = wrap_back && (cur_i.year == '0);
  assign over      = wrap_fwd && (cur_i.year >= cds_pkg::YEAR_MAX);
  assign len_prev  = cds_pkg::month_len(prev_m, leap_cur);
  assign len_next  = cds_pkg::month_len(next_m, leap_cur);

  assign day_plus7     = {1'b0, cur_i.day} + {1'b0, cds_pkg::WEEK_DAYS};
  assign week_back_day = {1'b0, cur_i.day} + {1'b0, len_prev} - {1'b0, cds_pkg::WEEK_DAYS};

  // load clamping
  assign ld_bad = (cmd_i.load_year > cds_pkg::YEAR_MAX);
  always_comb begin
    if (cmd_i.load_month == '0) begin
      ld_m = cds_pkg::JANUARY;
    end else if (cmd_i.load_month > cds_pkg::DECEMBER) begin
      ld_m = cds_pkg::DECEMBER;
    end else begin
      ld_m = cmd_i.load_month;
    end
  end
  assign ld_len = cds_pkg::month_len(ld_m, leap_ld);
  always_comb begin
    if (cmd_i.load_day == '0) begin
      ld_d = 5'd1;
    end else if (cmd_i.load_day > ld_len) begin
      ld_d = ld_len;
    end else begin
      ld_d = cmd_i.load_day;
    end
  end

  always_comb begin
    nxt    = cur_i;
    refuse = 1'b0;
    unique case (cmd_i.op)
      cds_pkg::OP_DAY_BACK: begin
        if (cur_i.day > 5'd1) begin
          nxt.day = cur_i.day - 5'd1;
        end else begin
          nxt    = '{year: prev_y, month: prev_m, day: len_prev};
          refuse = under;
        end
      end
      cds_pkg::OP_DAY_FWD: begin
        if (cur_i.day < dim) begin
          nxt.day = cur_i.day + 5'd1;
        end else begin
          nxt    = '{year: next_y, month: next_m, day: 5'd1};
          refuse = over;
        end
      end
      cds_pkg::OP_WEEK_BACK: begin
        if (cur_i.day > cds_pkg::WEEK_DAYS) begin
          nxt.day = cur_i.day - cds_pkg::WEEK_DAYS;
        end else begin
          nxt    = '{year: prev_y, month: prev_m, day: week_back_day[cds_pkg::DAY_W-1:0]};
          refuse = under;
        end
      end
      cds_pkg::OP_WEEK_FWD: begin
        if (day_plus7 <= {1'b0, dim}) begin
          nxt.day = day_plus7[cds_pkg::DAY_W-1:0];
        end else begin
          nxt.year  = next_y;
          nxt.month = next_m;
          nxt.day   = day_plus7[cds_pkg::DAY_W-1:0] - dim;
          refuse    = over;
        end
      end
      cds_pkg::OP_MONTH_BACK: begin
        nxt.year  = prev_y;
        nxt.month = prev_m;
        nxt.day   = (cur_i.day > len_prev) ? len_prev : cur_i.day;
        refuse    = under;
      end
      cds_pkg::OP_MONTH_FWD: begin
        nxt.year  = next_y;
        nxt.month = next_m;
        nxt.day   = (cur_i.day > len_next) ? len_next : cur_i.day;
        refuse    = over;
      end
      cds_pkg::OP_LOAD: begin
        nxt    = '{year: cmd_i.load_year, month: ld_m, day: ld_d};
        refuse = ld_bad;
      end
      cds_pkg::OP_NOP: begin
        nxt = cur_i;
      end
      default: begin
        nxt = cur_i;
      end
    endcase
  end

  // only a load can move into february of another year
  assign new_leap = (cmd_i.op == cds_pkg::OP_LOAD && !refuse) ? leap_ld : leap_cur;

  always_comb begin
    res_o.date         = refuse ? cur_i : nxt;
    res_o.month_length = cds_pkg::month_len(res_o.date.month, new_leap);
    res_o.limit_hit    = refuse;
  end

endmodule

FILE: hdl/calendar_date_stepper_unit.sv
// channel   direction  tdata fields (lsb first)                         notes
// s_axis    in         operation, load_year, load_month, load_day      one command a word
// m_axis    out        cur_year, cur_month, cur_day, month_length,     one result a word
//                      limit_hit
//
// one command per cycle sustained while m_axis accepts; a result passes through the input
// register, then the date logic into the result register
// the date register feeds back into the same cycle's step logic, which sets the pace
// reset gives 2000-01-01 with both pipeline registers empty
// a stalled m_axis holds its word; a new command still fills the input
// register, and s_axis_tready_o drops only when both registers are full
module calendar_date_stepper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] operation, [16:3] load_year, [20:17] load_month, [25:21] load_day, rest zero
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day, [27:23] month_length,
  // [28] limit_hit, rest zero
  output logic [31:0] m_axis_tdata_o
);

  cds_pkg::cmd_t  cmd_in;
  cds_pkg::cmd_t  cmd;
  logic           cmd_valid;
  logic           step;
  cds_pkg::date_t sel_q, sel_d;
  cds_pkg::res_t  res;
  cds_pkg::res_t  res_q;
  logic           out_valid_q, out_valid_d;

  // unpack the incoming word
  assign cmd_in.op         = cds_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign cmd_in.load_year  = s_axis_tdata_i[16:3];
  assign cmd_in.load_month = s_axis_tdata_i[20:17];
  assign cmd_in.load_day   = s_axis_tdata_i[25:21];

  // input register
  cds_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .cmd_i   (cmd_in),
    .valid_o (cmd_valid),
    .take_i  (step),
    .cmd_o   (cmd)
  );

  // next date from the held command and the selected date
  cds_date_next u_date_next (
    .cur_i (sel_q),
    .cmd_i (cmd),
    .res_o (res)
  );

  // a command executes when the result register is free or being drained
  assign step = cmd_valid && (!out_valid_q || m_axis_tready_i);

  // a refused command leaves the date as it was, which res.date already reflects
  assign sel_d       = step ? res.date : sel_q;
  assign out_valid_d = step ? 1'b1 : (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '{year: cds_pkg::RESET_YEAR, month: cds_pkg::RESET_MONTH,
                       day: cds_pkg::RESET_DAY};
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, res_q.limit_hit, res_q.month_length, res_q.date.day,
                            res_q.date.month, res_q.date.year};

  // selected month never leaves 1..12
  a_month_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q.month >= cds_pkg::JANUARY && sel_q.month <= cds_pkg::DECEMBER)
    else $error("selected month out of range");

  // a refused command must not move the date
  a_refuse_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.limit_hit |=> sel_q == $past(sel_q))
    else $error("date moved on a refused command");

  // the shown day always fits the shown month
  a_day_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.date.day >= 5'd1 && res_q.date.day <= res_q.month_length))
    else $error("result day outside month length");

  // a held command stays put while the result side is blocked
  a_cmd_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !step |=> cmd_valid && $stable(cmd))
    else $error("pending command lost or overwritten");

  // the date register only changes when a command executes
  a_sel_only_on_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(sel_q))
    else $error("date changed without a command");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_WORDS = 700;
  localparam int LIMIT_NS     = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;

  calendar_date_stepper_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  typedef struct {
    cds_pkg::cmd_t cmd;
    bit            typed;
    cds_pkg::res_t want;
  } stim_row_t;

  // shadow of the selected date
  int cal_year;
  int cal_month;
  int cal_day;

  cds_pkg::res_t expected_dates[$];
  stim_row_t     plan[$];
  int            mismatch_count;
  bit            send_calm;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int days_in(int y, int m);
    int mm;
    int n;
    mm = (m < int'(cds_pkg::JANUARY)) ? int'(cds_pkg::JANUARY)
       : (m > int'(cds_pkg::DECEMBER)) ? int'(cds_pkg::DECEMBER) : m;
    case (mm)
      int'(cds_pkg::FEBRUARY): n = 28;
      int'(cds_pkg::APRIL), int'(cds_pkg::JUNE), int'(cds_pkg::SEPTEMBER),
      int'(cds_pkg::NOVEMBER): n = 30;
      default: n = 31;
    endcase
    if (mm == int'(cds_pkg::FEBRUARY) && y >= 0 && y % 4 == 0 &&
        (y % 100 != 0 || y % 400 == 0)) begin
      n = 29;
    end
    return n;
  endfunction

  // applies one command to the shadow date and returns the word it should give
  function automatic cds_pkg::res_t advance_date(cds_pkg::cmd_t c);
    int            y;
    int            m;
    int            d;
    int            dim;
    int            nl;
    logic          refused;
    cds_pkg::res_t r;
    y = cal_year;
    m = cal_month;
    d = cal_day;
    dim = days_in(y, m);
    refused = 1'b0;
    case (c.op)
      cds_pkg::OP_DAY_BACK: begin
        d--;
        if (d < 1) begin
          m--;
          if (m < int'(cds_pkg::JANUARY)) begin
            m = int'(cds_pkg::DECEMBER);
            y--;
          end
          d = days_in(y, m);
        end
      end
      cds_pkg::OP_DAY_FWD: begin
        d++;
        if (d > dim) begin
          d = 1;
          m++;
          if (m > int'(cds_pkg::DECEMBER)) begin
            m = int'(cds_pkg::JANUARY);
            y++;
          end
        end
      end
      cds_pkg::OP_WEEK_BACK: begin
        d -= int'(cds_pkg::WEEK_DAYS);
        if (d < 1) begin
          m--;
          if (m < int'(cds_pkg::JANUARY)) begin
            m = int'(cds_pkg::DECEMBER);
            y--;
          end
          d += days_in(y, m);
          if (d < 1) d = 1;
        end
      end
      cds_pkg::OP_WEEK_FWD: begin
        d += int'(cds_pkg::WEEK_DAYS);
        if (d > dim) begin
          d -= dim;
          m++;
          if (m > int'(cds_pkg::DECEMBER)) begin
            m = int'(cds_pkg::JANUARY);
            y++;
          end
        end
      end
      cds_pkg::OP_MONTH_BACK: begin
        m--;
        if (m < int'(cds_pkg::JANUARY)) begin
          m = int'(cds_pkg::DECEMBER);
          y--;
        end
      end
      cds_pkg::OP_MONTH_FWD: begin
        m++;
        if (m > int'(cds_pkg::DECEMBER)) begin
          m = int'(cds_pkg::JANUARY);
          y++;
        end
      end
      cds_pkg::OP_LOAD: begin
        if (int'(c.load_year) > int'(cds_pkg::YEAR_MAX)) begin
          refused = 1'b1;
        end else begin
          y = int'(c.load_year);
          m = int'(c.load_month);
          if (m < int'(cds_pkg::JANUARY)) m = int'(cds_pkg::JANUARY);
          if (m > int'(cds_pkg::DECEMBER)) m = int'(cds_pkg::DECEMBER);
          d = (c.load_day == '0) ? 1 : int'(c.load_day);
        end
      end
      default: ;
    endcase
    // year range edge: below zero, or a carry past the top year
    if (c.op != cds_pkg::OP_LOAD &&
        (y < 0 || (y > cal_year && y > int'(cds_pkg::YEAR_MAX)))) begin
      refused = 1'b1;
    end
    if (!refused) begin
      nl = days_in(y, m);
      if (d > nl) d = nl;
      if (d < 1) d = 1;
      cal_year = y;
      cal_month = m;
      cal_day = d;
    end
    r.date.year = 14'(cal_year);
    r.date.month = 4'(cal_month);
    r.date.day = 5'(cal_day);
    r.month_length = 5'(days_in(cal_year, cal_month));
    r.limit_hit = refused;
    return r;
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic cds_pkg::cmd_t random_cmd();
    cds_pkg::cmd_t c;
    int            r;
    int            k;
    r = $urandom_range(0, 99);
    if (r < 12) c.op = cds_pkg::OP_LOAD;
    else if (r < 15) c.op = cds_pkg::OP_NOP;
    else c.op = cds_pkg::op_e'($urandom_range(0, 5));
    k = $urandom_range(0, 99);
    if (k < 25) begin
      // near the ends of the year range
      c.load_year = 14'(($urandom_range(0, 1) == 0)
                        ? $urandom_range(0, 2)
                        : $urandom_range(int'(cds_pkg::YEAR_MAX) - 2, cds_pkg::YEAR_MAX));
    end else if (k < 35) begin
      c.load_year = 14'($urandom_range(int'(cds_pkg::YEAR_MAX) + 1, 16383));
    end else if (k < 50) begin
      c.load_year = 14'($urandom_range(0, 99) * 100);
    end else begin
      c.load_year = 14'($urandom_range(0, cds_pkg::YEAR_MAX));
    end
    c.load_month = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(1, 12));
    c.load_day = 5'($urandom_range(0, 31));
    return c;
  endfunction

  task automatic add_row(input cds_pkg::op_e op, input int ly = 0, input int lm = 0,
                         input int ld = 0, input int ey = -1, input int em = 0,
                         input int ed = 0, input int el = 0, input int lim = 0);
    stim_row_t s;
    s.cmd.op = op;
    s.cmd.load_year = 14'(ly);
    s.cmd.load_month = 4'(lm);
    s.cmd.load_day = 5'(ld);
    s.typed = (ey >= 0);
    s.want.date.year = 14'((ey >= 0) ? ey : 0);
    s.want.date.month = 4'(em);
    s.want.date.day = 5'(ed);
    s.want.month_length = 5'(el);
    s.want.limit_hit = (lim != 0);
    plan.push_back(s);
  endtask

  // drives one command word and waits for it to be taken
  task automatic issue(input cds_pkg::cmd_t c, input bit typed, input cds_pkg::res_t want);
    int            gap;
    cds_pkg::res_t predicted;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'd0, c.load_day, c.load_month, c.load_year, c.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = advance_date(c);
    expected_dates.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: random stalls, with calm stretches
  initial begin
    int            stall_left;
    int            cycles;
    bit            recv_calm;
    cds_pkg::res_t e;
    stall_left = 0;
    cycles = 0;
    recv_calm = 1'b0;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_axis_tdata_o);
          mismatch_count++;
        end else begin
          e = expected_dates.pop_front();
          check_field("cur_year", int'(e.date.year), int'(m_axis_tdata_o[13:0]));
          check_field("cur_month", int'(e.date.month), int'(m_axis_tdata_o[17:14]));
          check_field("cur_day", int'(e.date.day), int'(m_axis_tdata_o[22:18]));
          check_field("month_length", int'(e.month_length), int'(m_axis_tdata_o[27:23]));
          check_field("limit_hit", int'(e.limit_hit), int'(m_axis_tdata_o[28]));
          check_field("padding", 0, int'(m_axis_tdata_o[31:29]));
        end
      end
      cycles++;
      if (cycles % 256 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!recv_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("calendar_date_stepper_unit regression: fail");
    $finish;
  end

  initial begin
    cds_pkg::res_t none;
    mismatch_count = 0;
    send_calm = 1'b0;
    none = '0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cal_year = int'(cds_pkg::RESET_YEAR);
    cal_month = int'(cds_pkg::RESET_MONTH);
    cal_day = int'(cds_pkg::RESET_DAY);

    // op, load y/m/d, then the expected word where it is obvious
    add_row(cds_pkg::OP_NOP, 0, 0, 0, 2000, 1, 1, 31, 0);
    add_row(cds_pkg::OP_LOAD, 0, 1, 1, 0, 1, 1, 31, 0);
    // refused below year zero
    add_row(cds_pkg::OP_DAY_BACK, 0, 0, 0, 0, 1, 1, 31, 1);
    add_row(cds_pkg::OP_WEEK_BACK, 0, 0, 0, 0, 1, 1, 31, 1);
    add_row(cds_pkg::OP_MONTH_BACK, 0, 0, 0, 0, 1, 1, 31, 1);
    add_row(cds_pkg::OP_LOAD, 9999, 12, 31, 9999, 12, 31, 31, 0);
    // refused past the top year
    add_row(cds_pkg::OP_DAY_FWD, 0, 0, 0, 9999, 12, 31, 31, 1);
    add_row(cds_pkg::OP_WEEK_FWD, 0, 0, 0, 9999, 12, 31, 31, 1);
    add_row(cds_pkg::OP_MONTH_FWD, 0, 0, 0, 9999, 12, 31, 31, 1);
    // load year too large
    add_row(cds_pkg::OP_LOAD, int'(cds_pkg::YEAR_MAX) + 1, 6, 15, 9999, 12, 31, 31, 1);
    add_row(cds_pkg::OP_LOAD, 16383, 15, 31, 9999, 12, 31, 31, 1);
    // month and day clamping on load, century leap rule
    add_row(cds_pkg::OP_LOAD, 2000, 0, 0, 2000, 1, 1, 31, 0);
    add_row(cds_pkg::OP_LOAD, 1900, 2, 31, 1900, 2, 28, 28, 0);
    add_row(cds_pkg::OP_LOAD, 2000, 2, 31, 2000, 2, 29, 29, 0);
    add_row(cds_pkg::OP_LOAD, 2004, 15, 31, 2004, 12, 31, 31, 0);
    // carries across month and year, checked by the predictor
    add_row(cds_pkg::OP_DAY_FWD);
    add_row(cds_pkg::OP_WEEK_BACK);
    add_row(cds_pkg::OP_LOAD, 2024, 3, 3);
    add_row(cds_pkg::OP_WEEK_BACK);
    add_row(cds_pkg::OP_LOAD, 2023, 1, 31);
    add_row(cds_pkg::OP_MONTH_FWD);
    add_row(cds_pkg::OP_DAY_FWD);
    add_row(cds_pkg::OP_DAY_BACK);
    add_row(cds_pkg::OP_LOAD, 2023, 3, 31);
    add_row(cds_pkg::OP_MONTH_BACK);
    add_row(cds_pkg::OP_WEEK_FWD);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) issue(plan[i].cmd, plan[i].typed, plan[i].want);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) send_calm = ($urandom_range(0, 2) == 0);
      issue(random_cmd(), 1'b0, none);
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("calendar_date_stepper_unit regression: pass");
    end else begin
      $display("calendar_date_stepper_unit regression: fail");
    end
    $finish;
  end

endmodule
